>>> rtl/mlrq_pkg.sv
`timescale 1ns / 1ps
package mlrq_pkg;

    // operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_PEEK  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam int DATA_W = 96;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  level;
        logic [31:0] slab_count;
        logic [31:0] request_id;
        logic [31:0] context_tag;
    } req_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              front_valid;
        logic [31:0]       front_id;
        logic [31:0]       front_slabs;
        logic [31:0]       front_tag;
        logic [8:0]        level_count;
        logic [8:0]        total_count;
        logic signed [3:0] lowest_pending;
    } res_item_t;

endpackage

>>> rtl/mlrq_ram.sv
`timescale 1ns / 1ps
module mlrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/multilevel_request_queue.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// request   start / busy           request (req_item_t)
// result    result_valid (strobe)  result  (res_item_t)
//
// Peek, clear and failed operations go through S_FETCH to the result strobe in
// S_OUT; add and pop first pass S_UPD, the read-modify-write of the link memory,
// ahead of the registered read of the entry memory in S_FETCH.
// busy stays high through the strobe cycle, so the next item is accepted only
// once the block is back in S_IDLE.
// Reset leaves every level empty at once; no clearing pass is needed.
// The result is shown for one cycle and cannot be stalled.
module multilevel_request_queue #(
    parameter int MAX_LEVEL  = 7,
    parameter int POOL_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mlrq_pkg::req_item_t  request,
    output logic                 busy,
    output logic                 result_valid,
    output mlrq_pkg::res_item_t  result
);
    import mlrq_pkg::*;

    localparam int NL = MAX_LEVEL + 1;
    localparam int LW = $clog2(NL);
    localparam int IW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_UPD   = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]    state_reg, state_next;
    req_item_t     req_reg, req_next;
    logic [3:0]    lvl_reg, lvl_next;
    logic [1:0]    status_reg, status_next;
    logic [IW-1:0] head_reg [NL];
    logic [IW-1:0] head_next [NL];
    logic [IW-1:0] tail_reg [NL];
    logic [IW-1:0] tail_next [NL];
    logic [CW-1:0] size_reg [NL];
    logic [CW-1:0] size_next [NL];
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] fresh_reg, fresh_next;
    logic [CW-1:0] rel_cnt_reg, rel_cnt_next;
    logic [IW-1:0] rel_top_reg, rel_top_next;

    logic              accept;
    logic [3:0]        clamp_lvl;
    logic [LW-1:0]     li;
    logic              in_range;
    logic [IW-1:0]     alloc_idx;
    logic              link_we;
    logic [IW-1:0]     link_waddr;
    logic [IW-1:0]     link_wdata;
    logic [IW-1:0]     link_raddr;
    logic [IW-1:0]     link_rdata;
    logic              data_we;
    logic [DATA_W-1:0] data_rdata;
    logic [3:0]        lowest;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign clamp_lvl = (request.level > 4'(MAX_LEVEL)) ? 4'(MAX_LEVEL) : request.level;
    assign li        = lvl_reg[LW-1:0];
    assign in_range  = (lvl_reg <= 4'(MAX_LEVEL));
    assign alloc_idx = (rel_cnt_reg != '0) ? rel_top_reg : fresh_reg[IW-1:0];

    // read the link of the free stack top, or of the level head for a pop
    assign link_raddr = (request.operation == OP_POP)
                        ? head_reg[clamp_lvl[LW-1:0]] : rel_top_reg;

    mlrq_ram #(.WIDTH(IW), .DEPTH(POOL_DEPTH)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    mlrq_ram #(.WIDTH(DATA_W), .DEPTH(POOL_DEPTH)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (alloc_idx),
        .wdata ({req_reg.request_id, req_reg.slab_count, req_reg.context_tag}),
        .raddr (head_reg[li]),
        .rdata (data_rdata)
    );

    // sequence one operation
    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        lvl_next     = lvl_reg;
        status_next  = status_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        size_next    = size_reg;
        total_next   = total_reg;
        fresh_next   = fresh_reg;
        rel_cnt_next = rel_cnt_reg;
        rel_top_next = rel_top_reg;
        link_we      = 1'b0;
        link_waddr   = alloc_idx;
        link_wdata   = alloc_idx;
        data_we      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next    = request;
                    status_next = ST_OK;
                    state_next  = S_FETCH;
                    lvl_next    = request.level;
                    if (request.operation == OP_ADD)
                    begin
                        lvl_next = clamp_lvl;
                        if (total_reg == CW'(POOL_DEPTH))
                            status_next = ST_FULL;
                        else
                            state_next = S_UPD;
                    end
                    else if (request.operation == OP_CLEAR)
                    begin
                        // drop every entry: restart the pool
                        for (int i = 0; i < NL; i++)
                        begin
                            size_next[i] = '0;
                        end
                        total_next   = '0;
                        fresh_next   = '0;
                        rel_cnt_next = '0;
                    end
                    else if (request.level > 4'(MAX_LEVEL))
                        status_next = ST_RANGE;
                    else if (size_reg[request.level[LW-1:0]] == '0)
                        status_next = ST_EMPTY;
                    else if (request.operation == OP_POP)
                        state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                state_next = S_FETCH;
                if (req_reg.operation == OP_ADD)
                begin
                    // take an entry, store the item, link it at the tail
                    data_we = 1'b1;
                    if (rel_cnt_reg != '0)
                    begin
                        rel_top_next = link_rdata;
                        rel_cnt_next = rel_cnt_reg - 1'b1;
                    end
                    else
                        fresh_next = fresh_reg + 1'b1;
                    if (size_reg[li] != '0)
                    begin
                        link_we    = 1'b1;
                        link_waddr = tail_reg[li];
                    end
                    else
                        head_next[li] = alloc_idx;
                    tail_next[li] = alloc_idx;
                    size_next[li] = size_reg[li] + 1'b1;
                    total_next    = total_reg + 1'b1;
                end
                else
                begin
                    // unlink the head and push it on the free stack
                    head_next[li] = link_rdata;
                    size_next[li] = size_reg[li] - 1'b1;
                    total_next    = total_reg - 1'b1;
                    link_we       = 1'b1;
                    link_waddr    = head_reg[li];
                    link_wdata    = rel_top_reg;
                    rel_top_next  = head_reg[li];
                    rel_cnt_next  = rel_cnt_reg + 1'b1;
                end
            end
            S_FETCH:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            fresh_reg   <= '0;
            rel_cnt_reg <= '0;
            rel_top_reg <= '0;
            for (int i = 0; i < NL; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                size_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            fresh_reg   <= fresh_next;
            rel_cnt_reg <= rel_cnt_next;
            rel_top_reg <= rel_top_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            size_reg    <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        lvl_reg    <= lvl_next;
        status_reg <= status_next;
    end

    // find the lowest non-empty level
    always_comb
    begin
        lowest = 4'hF;
        for (int i = NL - 1; i >= 0; i--)
        begin
            if (size_reg[i] != '0)
                lowest = 4'(i);
        end
    end

    // build the result item
    always_comb
    begin
        result                = '0;
        result.status         = status_reg;
        result.total_count    = 9'(total_reg);
        result.lowest_pending = lowest;
        if (in_range)
        begin
            result.level_count = 9'(size_reg[li]);
            if (size_reg[li] != '0)
            begin
                result.front_valid = 1'b1;
                result.front_id    = data_rdata[95:64];
                result.front_slabs = data_rdata[63:32];
                result.front_tag   = data_rdata[31:0];
            end
        end
    end

    assign result_valid = (state_reg == S_OUT);

endmodule

>>> rtl/mlrq_checker.sv
`timescale 1ns / 1ps
module mlrq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                result_valid,
    input mlrq_pkg::res_item_t result
);
    import mlrq_pkg::*;

    // an accepted item keeps the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after accept");

    // a result only closes an operation in progress
    a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy) else $error("result outside an operation");

    // the block frees itself after the result
    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !busy && !result_valid) else $error("busy after result");

    // an empty or out-of-range level never shows a front entry
    a_no_front_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == ST_EMPTY || result.status == ST_RANGE))
        |-> !result.front_valid) else $error("front entry on failed lookup");

endmodule

bind multilevel_request_queue mlrq_checker u_mlrq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

>>> tb/sv/queue_result_checker.sv
`timescale 1ns / 1ps
module queue_result_checker #(
    parameter int MAX_LEVEL  = 7,
    parameter int POOL_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  mlrq_pkg::req_item_t request,
    input  logic                result_valid,
    input  mlrq_pkg::res_item_t result,
    output int                  error_count,
    output int                  pending_count,
    output int                  results_seen
);
    import mlrq_pkg::*;

    localparam int LEVELS = MAX_LEVEL + 1;
    localparam int EXP_DEPTH = 8;

    // shadow copy of the pool
    logic [31:0] pool_id    [POOL_DEPTH];
    logic [31:0] pool_slabs [POOL_DEPTH];
    logic [31:0] pool_tag   [POOL_DEPTH];
    int          pool_link  [POOL_DEPTH];
    int          lvl_head   [LEVELS];
    int          lvl_tail   [LEVELS];
    int          lvl_size   [LEVELS];
    int          free_first;
    int          free_last;
    int          free_left;
    int          queued;

    // expected results waiting for their strobe
    res_item_t   exp_fifo [EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;

    assign pending_count = exp_wr - exp_rd;

    // append an entry to the free list
    function automatic void free_entry(int idx);
        if (free_left == 0)
            free_first = idx;
        else
            pool_link[free_last] = idx;
        free_last = idx;
        free_left++;
    endfunction

    function automatic void drop_head(int lv);
        int idx;
        idx = lvl_head[lv];
        lvl_head[lv] = pool_link[idx];
        lvl_size[lv]--;
        queued--;
        free_entry(idx);
    endfunction

    function automatic void reset_queue();
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            pool_link[i] = (i + 1) % POOL_DEPTH;
            pool_id[i] = '0;
            pool_slabs[i] = '0;
            pool_tag[i] = '0;
        end
        for (int i = 0; i < LEVELS; i++)
        begin
            lvl_head[i] = 0;
            lvl_tail[i] = 0;
            lvl_size[i] = 0;
        end
        free_first = 0;
        free_last = POOL_DEPTH - 1;
        free_left = POOL_DEPTH;
        queued = 0;
    endfunction

    // apply one item to the shadow state and return its result
    function automatic res_item_t apply_request(req_item_t rq);
        res_item_t r;
        int lv;
        int idx;
        lv = rq.level;
        r = '0;
        r.status = ST_OK;
        if (rq.operation == OP_ADD)
        begin
            if (lv > MAX_LEVEL)
                lv = MAX_LEVEL;
            if (free_left == 0)
                r.status = ST_FULL;
            else
            begin
                idx = free_first;
                free_first = pool_link[idx];
                free_left--;
                pool_slabs[idx] = rq.slab_count;
                pool_id[idx] = rq.request_id;
                pool_tag[idx] = rq.context_tag;
                if (lvl_size[lv] == 0)
                    lvl_head[lv] = idx;
                else
                    pool_link[lvl_tail[lv]] = idx;
                lvl_tail[lv] = idx;
                lvl_size[lv]++;
                queued++;
            end
        end
        else if (rq.operation == OP_CLEAR)
        begin
            for (int i = 0; i < LEVELS; i++)
                while (lvl_size[i] != 0)
                    drop_head(i);
        end
        else if (lv > MAX_LEVEL)
            r.status = ST_RANGE;
        else if (lvl_size[lv] == 0)
            r.status = ST_EMPTY;
        else if (rq.operation == OP_POP)
            drop_head(lv);

        if (lv <= MAX_LEVEL)
        begin
            r.level_count = 9'(lvl_size[lv]);
            if (lvl_size[lv] != 0)
            begin
                r.front_valid = 1'b1;
                r.front_id = pool_id[lvl_head[lv]];
                r.front_slabs = pool_slabs[lvl_head[lv]];
                r.front_tag = pool_tag[lvl_head[lv]];
            end
        end
        r.total_count = 9'(queued);
        r.lowest_pending = -4'sd1;
        for (int i = LEVELS - 1; i >= 0; i--)
            if (lvl_size[i] != 0)
                r.lowest_pending = 4'(i);
        return r;
    endfunction

    // predict on acceptance, compare on strobe
    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            reset_queue();
            exp_wr = 0;
            exp_rd = 0;
            error_count <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                results_seen <= results_seen + 1;
                if (exp_wr == exp_rd)
                begin
                    $display("%0t: unexpected result %p", $time, result);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = exp_fifo[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (result !== want)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, result);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                exp_fifo[exp_wr % EXP_DEPTH] = apply_request(request);
                exp_wr++;
            end
        end
    end

endmodule

>>> tb/sv/multilevel_request_queue_test.sv
`timescale 1ns / 1ps
module multilevel_request_queue_test;
    import mlrq_pkg::*;

    localparam int MAX_LEVEL  = 7;
    localparam int POOL_DEPTH = 256;
    localparam int STALL_LIMIT = 2000;

    logic      clk;
    logic      rst_n;
    logic      start;
    req_item_t request;
    logic      busy;
    logic      result_valid;
    res_item_t result;
    int        error_count;
    int        pending_count;
    int        results_seen;
    int        idle_cycles = 0;
    int        items_sent;
    int        adds_sent;
    int        full_hits;

    multilevel_request_queue #(.MAX_LEVEL(MAX_LEVEL), .POOL_DEPTH(POOL_DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .request(request),
        .busy(busy), .result_valid(result_valid), .result(result)
    );

    queue_result_checker #(.MAX_LEVEL(MAX_LEVEL), .POOL_DEPTH(POOL_DEPTH)) checker_u (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .result_valid(result_valid), .result(result), .error_count(error_count),
        .pending_count(pending_count), .results_seen(results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog: end the run after a long stretch with nothing accepted and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("multilevel_request_queue_test: errors");
            $finish;
        end
    end

    // hold one item until accepted, after a random gap
    task automatic send_item(logic [1:0] op, logic [3:0] lv, logic [31:0] slabs,
                             logic [31:0] id, logic [31:0] tag, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= '{operation: op, level: lv, slab_count: slabs,
                     request_id: id, context_tag: tag};
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent++;
        if (op == OP_ADD)
            adds_sent++;
    endtask

    task automatic send_random(logic [1:0] op, logic [3:0] lv, bit no_gap);
        send_item(op, lv, $urandom, $urandom, $urandom, no_gap);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    initial
    begin
        bit burst;
        int pick;
        start = 1'b0;
        request = '0;
        rst_n = 1'b0;
        items_sent = 0;
        adds_sent = 0;
        full_hits = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, range, extremes, clamp
        send_random(OP_PEEK, 4'd0, 0);
        send_random(OP_POP, 4'd7, 0);
        send_random(OP_PEEK, 4'd15, 0);
        send_random(OP_POP, 4'd8, 0);
        send_item(OP_ADD, 4'd0, '0, '0, '0, 0);
        send_item(OP_ADD, 4'd0, '1, '1, '1, 0);
        send_item(OP_ADD, 4'd15, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h0F0F_F0F0, 1);
        send_item(OP_ADD, 4'd9, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        send_random(OP_PEEK, 4'd7, 0);
        send_random(OP_PEEK, 4'd0, 1);
        send_random(OP_POP, 4'd0, 0);
        send_random(OP_POP, 4'd7, 0);
        send_random(OP_PEEK, 4'd12, 0);
        send_random(OP_ADD, 4'd3, 0);
        send_random(OP_CLEAR, 4'd15, 0);
        send_random(OP_PEEK, 4'd3, 0);
        send_random(OP_CLEAR, 4'd0, 0);

        // fill the pool, overflow it, then clear
        for (int i = 0; i < POOL_DEPTH + 3; i++)
            send_random(OP_ADD, 4'($urandom_range(0, 15)), $urandom_range(0, 1));
        full_hits += 3;
        drain();
        send_random(OP_POP, 4'($urandom_range(0, 7)), 1);
        send_random(OP_ADD, 4'd15, 1);
        send_random(OP_ADD, 4'd2, 1);
        send_random(OP_CLEAR, 4'd5, 0);

        // random: mixed traffic, some bursts sent back to back
        while (items_sent < 1700)
        begin
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 40; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < (burst ? 5 : 2))
                    send_random(OP_CLEAR, 4'($urandom), burst);
                else if (pick < 50)
                    send_random(OP_ADD, 4'($urandom), burst);
                else if (pick < 80)
                    send_random(OP_POP, 4'($urandom_range(0, 9)), burst);
                else
                    send_random(OP_PEEK, 4'($urandom), burst);
            end
            if ($urandom_range(0, 7) == 0)
                drain();
        end

        drain();
        repeat (10) @(posedge clk);
        $display("covered %0d items (%0d adds, pool overflow hits %0d), %0d results checked",
                 items_sent, adds_sent, full_hits, results_seen);
        if (error_count == 0 && pending_count == 0)
            $display("multilevel_request_queue_test: clean");
        else
            $display("multilevel_request_queue_test: errors");
        $finish;
    end

endmodule

>>> files.f
rtl/mlrq_pkg.sv
rtl/mlrq_ram.sv
rtl/multilevel_request_queue.sv
rtl/mlrq_checker.sv
tb/sv/queue_result_checker.sv
tb/sv/multilevel_request_queue_test.sv
